### design/rbp_pkg.sv
// Shared types and constants for the retry backoff policy block.
package rbp_pkg;

  // Register map: byte address bits [4:2] select the register
  localparam int unsigned AddrWidth = 5;
  localparam logic [2:0] REG_MAX_RETRIES     = 3'd0;
  localparam logic [2:0] REG_FALLBACK_ENABLE = 3'd1;
  localparam logic [2:0] REG_BASE_DELAY      = 3'd2;
  localparam logic [2:0] REG_MAX_DELAY       = 3'd3;
  localparam logic [2:0] REG_BACKOFF_MODE    = 3'd4;

  // Reset values of the registers
  localparam logic [7:0]  RST_MAX_RETRIES     = 8'd3;
  localparam logic        RST_FALLBACK_ENABLE = 1'b1;
  localparam logic [15:0] RST_BASE_DELAY      = 16'd1000;
  localparam logic [23:0] RST_MAX_DELAY       = 24'd30000;
  localparam logic [1:0]  RST_BACKOFF_MODE    = 2'd0;

  // Backoff modes; the unused code behaves as fixed
  localparam logic [1:0] MODE_EXP    = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_FIXED  = 2'd2;

  // Error types that matter to the policy
  localparam logic [2:0] ERR_TIMEOUT      = 3'd1;
  localparam logic [2:0] ERR_RATE_LIMITED = 3'd2;
  localparam logic [2:0] ERR_API          = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN      = 3'd7;

  // Policy thresholds
  localparam logic [9:0]  API_RETRY_STATUS = 10'd500;
  localparam logic [15:0] STREAK_LIMIT     = 16'd3;
  localparam logic [7:0]  ATTEMPT_LIMIT    = 8'd10;
  localparam logic [7:0]  EXP_SHIFT_LIMIT  = 8'd24;

  typedef enum logic [1:0] {
    ACT_NOW      = 2'd0,
    ACT_LATER    = 2'd1,
    ACT_FALLBACK = 2'd2,
    ACT_FAIL     = 2'd3
  } action_t;

  typedef struct packed {
    logic [7:0]  max_retries;
    logic        fallback_enable;
    logic [15:0] base_delay;
    logic [23:0] max_delay;
    logic [1:0]  backoff_mode;
  } cfg_t;

  typedef struct packed {
    logic [2:0] error_type;
    logic [9:0] status_code;
    logic       unknown_retry;
    logic [7:0] attempt;
  } item_t;

  typedef struct packed {
    action_t action;
    logic    degraded;
  } decision_t;

endpackage

### design/rbp_cfg.sv
// Configuration register file with an APB-style access port.
module rbp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbp_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output rbp_pkg::cfg_t                  cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[rbp_pkg::AddrWidth-1:2];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_retries     <= rbp_pkg::RST_MAX_RETRIES;
      cfg.fallback_enable <= rbp_pkg::RST_FALLBACK_ENABLE;
      cfg.base_delay      <= rbp_pkg::RST_BASE_DELAY;
      cfg.max_delay       <= rbp_pkg::RST_MAX_DELAY;
      cfg.backoff_mode    <= rbp_pkg::RST_BACKOFF_MODE;
    end else if (wr_en) begin
      unique case (reg_sel)
        rbp_pkg::REG_MAX_RETRIES:     cfg.max_retries     <= pwdata[7:0];
        rbp_pkg::REG_FALLBACK_ENABLE: cfg.fallback_enable <= pwdata[0];
        rbp_pkg::REG_BASE_DELAY:      cfg.base_delay      <= pwdata[15:0];
        rbp_pkg::REG_MAX_DELAY:       cfg.max_delay       <= pwdata[23:0];
        rbp_pkg::REG_BACKOFF_MODE:    cfg.backoff_mode    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_sel)
      rbp_pkg::REG_MAX_RETRIES:     prdata = {24'd0, cfg.max_retries};
      rbp_pkg::REG_FALLBACK_ENABLE: prdata = {31'd0, cfg.fallback_enable};
      rbp_pkg::REG_BASE_DELAY:      prdata = {16'd0, cfg.base_delay};
      rbp_pkg::REG_MAX_DELAY:       prdata = {8'd0, cfg.max_delay};
      rbp_pkg::REG_BACKOFF_MODE:    prdata = {30'd0, cfg.backoff_mode};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

### design/rbp_delay.sv
// Retry delay: exponential, linear or fixed, capped at max_delay and floored at 1.
module rbp_delay (
  input  rbp_pkg::cfg_t cfg,
  input  logic [7:0]    attempt,
  output logic [23:0]   delay
);

  logic [38:0] exp_shift;
  logic        exp_over;
  logic [24:0] lin_prod;
  logic [23:0] raw;
  logic        raw_over;
  logic [23:0] capped;

  // Exponential term; a zero base never saturates
  assign exp_shift = {23'd0, cfg.base_delay} << attempt[4:0];
  assign exp_over  = (cfg.base_delay != 16'd0) &&
                     ((attempt >= rbp_pkg::EXP_SHIFT_LIMIT) || (exp_shift[38:24] != 15'd0));

  // Linear term: base times (attempt + 1)
  assign lin_prod = 25'(cfg.base_delay) * 25'({1'b0, attempt} + 9'd1);

  // Select the mode; anything that does not fit in 24 bits saturates to the cap
  always_comb begin
    unique case (cfg.backoff_mode)
      rbp_pkg::MODE_EXP: begin
        raw      = exp_shift[23:0];
        raw_over = exp_over;
      end
      rbp_pkg::MODE_LINEAR: begin
        raw      = lin_prod[23:0];
        raw_over = lin_prod[24];
      end
      default: begin
        raw      = {8'd0, cfg.base_delay};
        raw_over = 1'b0;
      end
    endcase
  end

  // Cap, then floor
  assign capped = (raw_over || (raw > cfg.max_delay)) ? cfg.max_delay : raw;
  assign delay  = (capped == 24'd0) ? 24'd1 : capped;

endmodule

### design/rbp_policy.sv
// Error classification, saturating error counters and action choice.
module rbp_policy (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  rbp_pkg::item_t       item,
  input  rbp_pkg::cfg_t        cfg,
  output rbp_pkg::decision_t   decision
);

  logic [31:0] total_count;
  logic [31:0] total_count_next;
  logic [31:0] retryable_count;
  logic [31:0] retryable_count_next;
  logic [15:0] streak_count;
  logic [15:0] streak_count_next;
  logic        degraded_flag;
  logic        degraded_flag_next;
  logic        retryable;
  logic        share_high;
  logic        degrade_hit;

  // Classify the error
  always_comb begin
    unique case (item.error_type)
      rbp_pkg::ERR_API:     retryable = (item.status_code >= rbp_pkg::API_RETRY_STATUS);
      rbp_pkg::ERR_UNKNOWN: retryable = item.unknown_retry;
      default:              retryable = 1'b1;
    endcase
  end

  // Saturating counter updates
  assign total_count_next = (total_count == '1) ? total_count : total_count + 32'd1;
  assign retryable_count_next =
      (retryable && (retryable_count != '1)) ? retryable_count + 32'd1 : retryable_count;
  always_comb begin
    if (!retryable) begin
      streak_count_next = 16'd0;
    end else if (streak_count == '1) begin
      streak_count_next = streak_count;
    end else begin
      streak_count_next = streak_count + 16'd1;
    end
  end

  // Retryable share above one half, with at least ten attempts made
  assign share_high = ({retryable_count_next, 1'b0} > {1'b0, total_count_next}) &&
                      (item.attempt >= rbp_pkg::ATTEMPT_LIMIT);
  assign degrade_hit = (streak_count_next >= rbp_pkg::STREAK_LIMIT) || share_high;

  // Choose the action; the first matching rule wins
  always_comb begin
    degraded_flag_next = degraded_flag;
    priority if (!retryable) begin
      decision.action = rbp_pkg::ACT_FAIL;
    end else if (item.attempt >= cfg.max_retries) begin
      decision.action = cfg.fallback_enable ? rbp_pkg::ACT_FALLBACK : rbp_pkg::ACT_FAIL;
    end else if (degrade_hit) begin
      degraded_flag_next = 1'b1;
      decision.action    = rbp_pkg::ACT_FALLBACK;
    end else if ((item.error_type == rbp_pkg::ERR_TIMEOUT) ||
                 (item.error_type == rbp_pkg::ERR_RATE_LIMITED)) begin
      decision.action = rbp_pkg::ACT_LATER;
    end else begin
      decision.action = rbp_pkg::ACT_NOW;
    end
    decision.degraded = degraded_flag_next;
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count     <= 32'd0;
      retryable_count <= 32'd0;
      streak_count    <= 16'd0;
      degraded_flag   <= 1'b0;
    end else if (advance) begin
      total_count     <= total_count_next;
      retryable_count <= retryable_count_next;
      streak_count    <= streak_count_next;
      degraded_flag   <= degraded_flag_next;
    end
  end

endmodule

### design/retry_backoff_policy_top.sv
// Top level of the retry backoff policy block: input register, policy, result register.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------------
//   in       | input     | in_valid / in_stall  | error_type, status_code, unknown_retry,
//            |           |                      | attempt
//   out      | output    | out_valid / out_stall| action, retry_delay, degraded
//   cfg      | input     | psel/penable/pready  | paddr, pwdata, prdata
//
// One error per clock when out is not stalled; a result passes from its transfer in
// through the input register, then the result register, with the policy and delay logic
// between them. Counter state commits as an item moves into the result register.
// rst is synchronous and clears the counters, the degraded flag, the config registers and
// both valid bits. A stalled result holds; the input register keeps taking an item
// until it is full too.
module retry_backoff_policy_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     error_type,
  input  logic [9:0]                     status_code,
  input  logic                           unknown_retry,
  input  logic [7:0]                     attempt,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     action,
  output logic [23:0]                    retry_delay,
  output logic                           degraded,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbp_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  rbp_pkg::cfg_t      cfg;
  rbp_pkg::item_t     s1_item;
  logic               s1_valid;
  rbp_pkg::decision_t decision;
  logic [23:0]        delay;
  logic               out_free;
  logic               advance;
  logic               s1_load;

  // Handshake control
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign s1_load  = in_valid && !in_stall;

  rbp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item.error_type    <= error_type;
      s1_item.status_code   <= status_code;
      s1_item.unknown_retry <= unknown_retry;
      s1_item.attempt       <= attempt;
    end
  end

  rbp_policy u_policy (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (s1_item),
    .cfg      (cfg),
    .decision (decision)
  );

  rbp_delay u_delay (
    .cfg     (cfg),
    .attempt (s1_item.attempt),
    .delay   (delay)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action      <= decision.action;
      retry_delay <= delay;
      degraded    <= decision.degraded;
    end
  end

endmodule

### tb/sv/tb_retry_backoff_policy_top.sv
// Self-checking testbench for the retry backoff policy block.
`timescale 1ns / 1ps

module tb_retry_backoff_policy_top;
  import rbp_pkg::*;

  // Error types the package leaves unnamed
  localparam logic [2:0] ERR_NETWORK     = 3'd0;
  localparam logic [2:0] ERR_INVALID     = 3'd4;
  localparam logic [2:0] ERR_PARSE       = 3'd5;
  localparam logic [2:0] ERR_UNAVAILABLE = 3'd6;

  localparam int PLAN_ROWS   = 18;
  localparam int PLAN_SPLIT  = 11;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 170;

  typedef struct packed {
    action_t     action;
    logic [23:0] delay;
    logic        degraded;
  } verdict_t;

  typedef struct packed {
    item_t    err;
    logic     typed;
    verdict_t want;
  } plan_row_t;

  localparam verdict_t NO_TYPED = '{ACT_NOW, 24'd0, 1'b0};

  // Directed table: reset settings first, then max retries raised to 255 with fallback off
  plan_row_t plan [PLAN_ROWS] = '{
    '{'{ERR_INVALID,     10'd0,   1'b0, 8'd0},   1'b1, '{ACT_NOW,      24'd1000,  1'b0}},
    '{'{ERR_API,         10'd499, 1'b0, 8'd0},   1'b1, '{ACT_FAIL,     24'd1000,  1'b0}},
    '{'{ERR_API,         10'd500, 1'b0, 8'd1},   1'b1, '{ACT_NOW,      24'd2000,  1'b0}},
    '{'{ERR_UNKNOWN,     10'd999, 1'b0, 8'd0},   1'b1, '{ACT_FAIL,     24'd1000,  1'b0}},
    '{'{ERR_UNKNOWN,     10'd0,   1'b1, 8'd2},   1'b1, '{ACT_NOW,      24'd4000,  1'b0}},
    '{'{ERR_TIMEOUT,     10'd200, 1'b1, 8'd0},   1'b1, '{ACT_LATER,    24'd1000,  1'b0}},
    '{'{ERR_RATE_LIMITED, 10'd429, 1'b0, 8'd3},  1'b1, '{ACT_FALLBACK, 24'd8000,  1'b0}},
    '{'{ERR_NETWORK,     10'd0,   1'b0, 8'd1},   1'b1, '{ACT_FALLBACK, 24'd2000,  1'b1}},
    '{'{ERR_INVALID,     10'd24,  1'b0, 8'd255}, 1'b1, '{ACT_FALLBACK, 24'd30000, 1'b1}},
    '{'{ERR_PARSE,       10'd1,   1'b1, 8'd5},   1'b1, '{ACT_FALLBACK, 24'd30000, 1'b1}},
    '{'{ERR_UNAVAILABLE, 10'd503, 1'b0, 8'd4},   1'b1, '{ACT_FALLBACK, 24'd16000, 1'b1}},
    '{'{ERR_NETWORK,     10'd0,   1'b0, 8'd10},  1'b0, NO_TYPED},
    '{'{ERR_API,         10'd404, 1'b0, 8'd255}, 1'b1, '{ACT_FAIL,     24'd30000, 1'b1}},
    '{'{ERR_NETWORK,     10'd0,   1'b0, 8'd255}, 1'b1, '{ACT_FAIL,     24'd30000, 1'b1}},
    '{'{ERR_TIMEOUT,     10'd0,   1'b0, 8'd11},  1'b0, NO_TYPED},
    '{'{ERR_RATE_LIMITED, 10'd0,  1'b0, 8'd9},   1'b0, NO_TYPED},
    '{'{ERR_INVALID,     10'd999, 1'b1, 8'd23},  1'b0, NO_TYPED},
    '{'{ERR_UNKNOWN,     10'd512, 1'b1, 8'd0},   1'b0, NO_TYPED}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [2:0]  error_type = '0;
  logic [9:0]  status_code = '0;
  logic        unknown_retry = 1'b0;
  logic [7:0]  attempt = '0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  action;
  logic [23:0] retry_delay;
  logic        degraded;
  logic [31:0] prdata;
  logic        pready;

  // Policy copy: settings and counters as the block should hold them
  cfg_t        policy_cfg;
  logic [31:0] err_total;
  logic [31:0] err_retryable;
  logic [15:0] err_streak;
  logic        deg_sticky;
  verdict_t    pending_verdicts [$];

  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int settings_applied = 0;
  bit calm = 1'b0;
  int send_mood_left = 0;
  bit send_mood = 1'b0;
  int stall_left = 0;
  int stall_mood_left = 0;
  bit stall_mood = 1'b0;

  retry_backoff_policy_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .error_type    (error_type),
    .status_code   (status_code),
    .unknown_retry (unknown_retry),
    .attempt       (attempt),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .action        (action),
    .retry_delay   (retry_delay),
    .degraded      (degraded),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // Delay for one attempt: shape by mode, clip to the cap, floor at one
  function automatic logic [23:0] backoff_delay(logic [7:0] att);
    logic [63:0] d;
    logic [63:0] cap;
    cap = 64'(policy_cfg.max_delay);
    case (policy_cfg.backoff_mode)
      MODE_EXP: begin
        if (policy_cfg.base_delay == '0) d = '0;
        else if (att >= EXP_SHIFT_LIMIT) d = cap;
        else d = 64'(policy_cfg.base_delay) << att;
      end
      MODE_LINEAR: d = 64'(policy_cfg.base_delay) * (64'(att) + 64'd1);
      default: d = 64'(policy_cfg.base_delay);
    endcase
    if (d > cap) d = cap;
    if (d < 64'd1) d = 64'd1;
    return d[23:0];
  endfunction

  // Classify one error, advance the counters and pick the action
  function automatic verdict_t policy_decide(item_t e);
    logic     go;
    verdict_t v;
    case (e.error_type)
      ERR_API: go = (e.status_code >= API_RETRY_STATUS);
      ERR_UNKNOWN: go = e.unknown_retry;
      default: go = 1'b1;
    endcase
    if (err_total != '1) err_total = err_total + 32'd1;
    if (go) begin
      if (err_retryable != '1) err_retryable = err_retryable + 32'd1;
      if (err_streak != '1) err_streak = err_streak + 16'd1;
    end else begin
      err_streak = '0;
    end
    if (!go) begin
      v.action = ACT_FAIL;
    end else if (e.attempt >= policy_cfg.max_retries) begin
      v.action = policy_cfg.fallback_enable ? ACT_FALLBACK : ACT_FAIL;
    end else if (err_streak >= STREAK_LIMIT ||
                 ({err_retryable, 1'b0} > {1'b0, err_total} &&
                  e.attempt >= ATTEMPT_LIMIT)) begin
      deg_sticky = 1'b1;
      v.action = ACT_FALLBACK;
    end else if (e.error_type == ERR_TIMEOUT || e.error_type == ERR_RATE_LIMITED) begin
      v.action = ACT_LATER;
    end else begin
      v.action = ACT_NOW;
    end
    v.delay = backoff_delay(e.attempt);
    v.degraded = deg_sticky;
    return v;
  endfunction

  function automatic logic [9:0] random_status();
    case ($urandom_range(0, 2))
      0: return 10'($urandom_range(0, 999));
      1: return 10'($urandom_range(490, 510));
      default: return 10'($urandom_range(500, 999));
    endcase
  endfunction

  function automatic item_t random_error();
    item_t e;
    int    lo;
    int    hi;
    e.error_type = 3'($urandom_range(0, 7));
    e.status_code = random_status();
    e.unknown_retry = 1'($urandom_range(0, 1));
    lo = (policy_cfg.max_retries > 3) ? int'(policy_cfg.max_retries) - 3 : 0;
    hi = (policy_cfg.max_retries > 252) ? 255 : int'(policy_cfg.max_retries) + 3;
    case ($urandom_range(0, 9))
      0, 1, 2: e.attempt = 8'($urandom_range(0, 255));
      3, 4, 5: e.attempt = 8'($urandom_range(0, 30));
      default: e.attempt = 8'($urandom_range(lo, hi));
    endcase
    return e;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected 0x%0h, got 0x%0h at %0t ns", what, want, got, $time);
  endtask

  // Offer one error, hold it until the transfer, then queue its expected result
  task automatic send_error(item_t e, logic typed, verdict_t want);
    int       gap;
    verdict_t predicted;
    gap = 0;
    if (!calm) begin
      if (send_mood_left == 0) begin
        send_mood_left = $urandom_range(10, 150);
        send_mood = ($urandom_range(0, 2) != 0);
      end else begin
        send_mood_left--;
      end
      if (send_mood && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    error_type <= e.error_type;
    status_code <= e.status_code;
    unknown_retry <= e.unknown_retry;
    attempt <= e.attempt;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = policy_decide(e);
    pending_verdicts = {pending_verdicts, (typed ? want : predicted)};
    items_sent++;
  endtask

  // Drop valid and let every queued result come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, mirror it, then read it back
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    logic [31:0] held;
    logic [31:0] mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (idx)
      REG_MAX_RETRIES: begin
        policy_cfg.max_retries = value[7:0];
        mask = 32'hFF;
      end
      REG_FALLBACK_ENABLE: begin
        policy_cfg.fallback_enable = value[0];
        mask = 32'h1;
      end
      REG_BASE_DELAY: begin
        policy_cfg.base_delay = value[15:0];
        mask = 32'hFFFF;
      end
      REG_MAX_DELAY: begin
        policy_cfg.max_delay = value[23:0];
        mask = 32'hFF_FFFF;
      end
      default: begin
        policy_cfg.backoff_mode = value[1:0];
        mask = 32'h3;
      end
    endcase
    held = value & mask;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if ((prdata & mask) !== held) flag_mismatch("register read", held, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write all five registers; upper data bits carry noise the block must drop
  task automatic apply_setting(logic [7:0] mr, logic fb, logic [15:0] base,
                               logic [23:0] maxd, logic [1:0] mode);
    write_reg(REG_MAX_RETRIES, {24'($urandom()), mr});
    write_reg(REG_FALLBACK_ENABLE, {31'($urandom()), fb});
    write_reg(REG_BASE_DELAY, {16'($urandom()), base});
    write_reg(REG_MAX_DELAY, {8'($urandom()), maxd});
    write_reg(REG_BACKOFF_MODE, {30'($urandom()), mode});
    settings_applied++;
  endtask

  // Mostly retry sessions with climbing attempts, some stray errors between them
  task automatic run_phase(int quota);
    int    sent;
    int    len;
    int    first;
    int    limit;
    item_t e;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 4) == 0) begin
        send_error(random_error(), 1'b0, NO_TYPED);
        sent++;
      end else begin
        e = random_error();
        limit = (policy_cfg.max_retries > 28) ? 30 : int'(policy_cfg.max_retries) + 2;
        len = $urandom_range(1, limit);
        first = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : 0;
        for (int a = 0; a < len && sent < quota; a++) begin
          e.attempt = 8'(first + a);
          if ($urandom_range(0, 3) == 0) e.status_code = random_status();
          if ($urandom_range(0, 5) == 0) e.error_type = 3'($urandom_range(0, 7));
          send_error(e, 1'b0, NO_TYPED);
          sent++;
        end
      end
    end
  endtask

  // Receiver: stall in bursts during busy moods, stay open during quiet ones
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_mood_left == 0) begin
        stall_mood_left = $urandom_range(20, 300);
        stall_mood = ($urandom_range(0, 2) != 0);
      end else begin
        stall_mood_left--;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (stall_mood && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("unexpected result", 32'd0, {30'd0, action});
      end else begin
        want = pending_verdicts.pop_front();
        if (action !== want.action)
          flag_mismatch("action", 32'(want.action), 32'(action));
        if (retry_delay !== want.delay)
          flag_mismatch("retry_delay", 32'(want.delay), 32'(retry_delay));
        if (degraded !== want.degraded)
          flag_mismatch("degraded", 32'(want.degraded), 32'(degraded));
      end
    end
  end

  initial begin
    int          directed;
    logic [7:0]  mr;
    logic [15:0] base;
    logic [23:0] maxd;
    policy_cfg = '{RST_MAX_RETRIES, RST_FALLBACK_ENABLE, RST_BASE_DELAY, RST_MAX_DELAY,
                   RST_BACKOFF_MODE};
    err_total = '0;
    err_retryable = '0;
    err_streak = '0;
    deg_sticky = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (i == PLAN_SPLIT) begin
        drain();
        apply_setting(8'd255, 1'b0, RST_BASE_DELAY, RST_MAX_DELAY, RST_BACKOFF_MODE);
      end
      send_error(plan[i].err, plan[i].typed, plan[i].want);
    end
    directed = items_sent;

    // Random phases: extremes first, then random settings
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: apply_setting(8'd0, 1'b0, 16'd0, 24'd0, 2'd3);
        1: apply_setting(8'd255, 1'b1, 16'hFFFF, 24'hFF_FFFF, MODE_LINEAR);
        2: apply_setting(8'd255, 1'b0, 16'hFFFF, 24'hFF_FFFF, MODE_EXP);
        3: apply_setting(8'd1, 1'b1, 16'd1, 24'd1, MODE_FIXED);
        default: begin
          case ($urandom_range(0, 2))
            0: mr = 8'($urandom_range(0, 4));
            1: mr = 8'($urandom_range(5, 40));
            default: mr = 8'($urandom_range(0, 255));
          endcase
          base = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 50)) : 16'($urandom());
          maxd = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(1, 5000))
                                              : 24'($urandom_range(1, 24'hFF_FFFF));
          apply_setting(mr, 1'($urandom_range(0, 1)), base, maxd, 2'($urandom_range(0, 3)));
        end
      endcase
      if (phase == PHASES - 1) calm = 1'b1;
      run_phase(PHASE_ITEMS);
    end
    drain();

    $display("covered %0d error transfers (%0d directed) under %0d register settings",
             items_sent, directed, settings_applied);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", pending_verdicts.size());
    $display("simulation failed");
    $finish;
  end

endmodule
